// ===== rtl/rspp_pkg.sv =====
// shared types, widths, constants and the arctangent table of the particle pool
package rspp_pkg;

    localparam int SLOTS  = 16;
    localparam int SLOT_W = $clog2(SLOTS);

    localparam int TRIG_W = 34;
    localparam int Z_W    = 25;
    localparam int ITER   = 16;
    localparam int ITER_W = $clog2(ITER);
    localparam int LEN_W  = 17;
    localparam int PROD_W = 52;
    localparam int FRAC   = 30;
    localparam int PQ_W   = 20;
    localparam int PX_W   = 21;
    localparam int VS_W   = 22;

    localparam logic signed [TRIG_W-1:0] CORDIC_K  = 34'sd652032874;
    localparam logic signed [PROD_W-1:0] PROD_HALF = 52'sd536870912;
    localparam logic [9:0] RADIUS_STEP_RESET = 10'd16;

    localparam logic KIND_SPAWN = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    typedef struct packed {
        logic        start;
        logic        vec;
        logic [15:0] angle;
        logic [14:0] size_x;
        logic [14:0] size_y;
    } cord_cmd_t;

    typedef logic [3:0][9:0] color_t;

    function automatic logic signed [Z_W-1:0] atan_lut(input logic [ITER_W-1:0] i);
        logic signed [Z_W-1:0] v;
        unique case (i)
            4'd0:    v = 25'sd2097152;
            4'd1:    v = 25'sd1238021;
            4'd2:    v = 25'sd654136;
            4'd3:    v = 25'sd332050;
            4'd4:    v = 25'sd166669;
            4'd5:    v = 25'sd83416;
            4'd6:    v = 25'sd41718;
            4'd7:    v = 25'sd20860;
            4'd8:    v = 25'sd10430;
            4'd9:    v = 25'sd5215;
            4'd10:   v = 25'sd2608;
            4'd11:   v = 25'sd1304;
            4'd12:   v = 25'sd652;
            4'd13:   v = 25'sd326;
            4'd14:   v = 25'sd163;
            default: v = 25'sd81;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/rspp_if.sv =====
// request and result channel interfaces of the particle pool
interface rspp_req_if;
    logic               valid;
    logic               ready;
    logic               kind;
    logic signed [15:0] center_x;
    logic signed [15:0] center_y;
    logic [14:0]        size_x;
    logic [14:0]        size_y;
    logic [15:0]        fire_angle;
    logic [31:0]        start_color;
    logic [31:0]        color_step;
    logic [15:0]        lifetime;

    modport source(output valid, kind, center_x, center_y, size_x, size_y, fire_angle,
                   start_color, color_step, lifetime, input ready);
    modport sink(input valid, kind, center_x, center_y, size_x, size_y, fire_angle,
                 start_color, color_step, lifetime, output ready);
endinterface

interface rspp_rsp_if;
    logic               valid;
    logic               ready;
    logic               is_vertex;
    logic               spawn_ok;
    logic [3:0]         slot_index;
    logic [1:0]         corner;
    logic signed [15:0] vertex_x;
    logic signed [15:0] vertex_y;
    logic [31:0]        vertex_color;
    logic               last;

    modport source(output valid, is_vertex, spawn_ok, slot_index, corner, vertex_x, vertex_y,
                   vertex_color, last, input ready);
    modport sink(input valid, is_vertex, spawn_ok, slot_index, corner, vertex_x, vertex_y,
                 vertex_color, last, output ready);
endinterface

// ===== rtl/rspp_cordic.sv =====
// iterative cordic, rotation mode for sine and cosine, vectoring mode for the corner angle
module rspp_cordic
    import rspp_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cord_cmd_t                cmd,
    output logic                     busy,
    output logic signed [TRIG_W-1:0] cos_val,
    output logic signed [TRIG_W-1:0] sin_val,
    output logic [15:0]              atan_val
);

    logic signed [TRIG_W-1:0] x_reg, y_reg, x_next, y_next, x_sh, y_sh;
    logic signed [Z_W-1:0]    z_reg, z_next, z_rnd, z_q;
    logic [ITER_W-1:0]        it_reg;
    logic                     busy_reg, vec_reg, zero_reg;
    logic [1:0]               q_reg;
    logic [16:0]              ang_sum;
    logic [1:0]               q_start;
    logic [15:0]              red;
    logic                     dir_pos;

    assign ang_sum = {1'b0, cmd.angle} + 17'd8192;
    assign q_start = ang_sum[15:14];
    assign red     = cmd.angle - {q_start, 14'd0};

    assign x_sh    = x_reg >>> it_reg;
    assign y_sh    = y_reg >>> it_reg;
    assign dir_pos = vec_reg ? y_reg[TRIG_W-1] : !z_reg[Z_W-1];

    always_comb
    begin
        if (dir_pos)
        begin
            x_next = x_reg - y_sh;
            y_next = y_reg + x_sh;
            z_next = z_reg - atan_lut(it_reg);
        end
        else
        begin
            x_next = x_reg + y_sh;
            y_next = y_reg - x_sh;
            z_next = z_reg + atan_lut(it_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            it_reg   <= '0;
        end
        else if (cmd.start)
        begin
            busy_reg <= 1'b1;
            it_reg   <= '0;
        end
        else if (busy_reg)
        begin
            it_reg <= it_reg + 1'b1;
            if (it_reg == ITER_W'(ITER - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            vec_reg  <= cmd.vec;
            zero_reg <= (cmd.size_x == '0) && (cmd.size_y == '0);
            if (cmd.vec)
            begin
                x_reg <= TRIG_W'({cmd.size_x, 15'd0});
                y_reg <= TRIG_W'({cmd.size_y, 15'd0});
                z_reg <= '0;
                q_reg <= '0;
            end
            else
            begin
                x_reg <= CORDIC_K;
                y_reg <= '0;
                z_reg <= Z_W'($signed({red, 8'd0}));
                q_reg <= q_start;
            end
        end
        else if (busy_reg)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    always_comb
    begin
        case (q_reg)
            2'd0:
            begin
                cos_val = x_reg;
                sin_val = y_reg;
            end
            2'd1:
            begin
                cos_val = -y_reg;
                sin_val = x_reg;
            end
            2'd2:
            begin
                cos_val = -x_reg;
                sin_val = -y_reg;
            end
            default:
            begin
                cos_val = y_reg;
                sin_val = -x_reg;
            end
        endcase
    end

    assign z_rnd = z_reg + 25'sd128;
    assign z_q   = z_rnd >>> 8;

    always_comb
    begin
        if (zero_reg || z_q < 0)
        begin
            atan_val = '0;
        end
        else if (z_q > 25'sd16384)
        begin
            atan_val = 16'd16384;
        end
        else
        begin
            atan_val = z_q[15:0];
        end
    end

    assign busy = busy_reg;

endmodule

// ===== rtl/rspp_mul.sv =====
// bit-serial multiplier, one length bit per cycle, product rounded at 2^-30
module rspp_mul
    import rspp_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [LEN_W-1:0]         len,
    input  logic signed [TRIG_W-1:0] fac,
    output logic                     busy,
    output logic signed [PQ_W-1:0]   prod
);

    logic [LEN_W-1:0]         len_reg;
    logic signed [TRIG_W-1:0] fac_reg;
    logic signed [PROD_W-1:0] acc_reg, rnd_sum, rnd_q;
    logic [$clog2(LEN_W)-1:0] cnt_reg;
    logic                     busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == $clog2(LEN_W)'(LEN_W - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            len_reg <= len;
            fac_reg <= fac;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            len_reg <= {len_reg[LEN_W-2:0], 1'b0};
            acc_reg <= (acc_reg <<< 1) + (len_reg[LEN_W-1] ? PROD_W'(fac_reg) : '0);
        end
    end

    assign rnd_sum = acc_reg + PROD_HALF;
    assign rnd_q   = rnd_sum >>> FRAC;
    assign prod    = rnd_q[PQ_W-1:0];
    assign busy    = busy_reg;

endmodule

// ===== rtl/rspp_sqrt.sv =====
// rounded square root of size_x^2 + size_y^2, one root bit per cycle
module rspp_sqrt
    import rspp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [14:0]      size_x,
    input  logic [14:0]      size_y,
    output logic             busy,
    output logic [LEN_W-1:0] root
);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_SUM  = 2'd1;
    localparam logic [1:0] PH_ITER = 2'd2;
    localparam logic [1:0] PH_FIN  = 2'd3;

    logic [1:0]  ph_reg;
    logic [3:0]  b_reg;
    logic [29:0] sqx_reg, sqy_reg;
    logic [31:0] m_reg, r_reg, bitv, trial;

    assign bitv  = 32'd1 << {b_reg, 1'b0};
    assign trial = r_reg + bitv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg <= PH_IDLE;
            b_reg  <= '0;
        end
        else
        begin
            unique case (ph_reg)
                PH_IDLE:
                begin
                    if (start)
                    begin
                        ph_reg <= PH_SUM;
                    end
                end
                PH_SUM:
                begin
                    ph_reg <= PH_ITER;
                    b_reg  <= 4'd15;
                end
                PH_ITER:
                begin
                    b_reg <= b_reg - 1'b1;
                    if (b_reg == 4'd0)
                    begin
                        ph_reg <= PH_FIN;
                    end
                end
                PH_FIN:
                begin
                    ph_reg <= PH_IDLE;
                end
                default:
                begin
                    ph_reg <= PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (ph_reg == PH_IDLE && start)
        begin
            sqx_reg <= size_x * size_x;
            sqy_reg <= size_y * size_y;
        end
        if (ph_reg == PH_SUM)
        begin
            m_reg <= 32'(sqx_reg) + 32'(sqy_reg);
            r_reg <= '0;
        end
        else if (ph_reg == PH_ITER)
        begin
            if (m_reg >= trial)
            begin
                m_reg <= m_reg - trial;
                r_reg <= (r_reg >> 1) + bitv;
            end
            else
            begin
                r_reg <= r_reg >> 1;
            end
        end
        else if (ph_reg == PH_FIN)
        begin
            if (m_reg > r_reg)
            begin
                r_reg <= r_reg + 32'd1;
            end
        end
    end

    assign busy = (ph_reg != PH_IDLE);
    assign root = r_reg[LEN_W-1:0];

endmodule

// ===== rtl/rotated_sprite_particle_pool_top.sv =====
// top level of the rotated sprite particle pool: slot store, sequencer and output stage
//
// req carries spawn and tick words, rsp carries reply and vertex words; a word
// moves at a clock edge with valid and ready both high. cfg_wr_en writes
// radius_step from cfg_wr_data.
// a spawn takes the lowest free slot and returns one reply word once the
// 16-step square root, which runs beside the vectoring cordic, is done.
// a tick walks all slots: a free or dying slot is settled in its slot step, a
// surviving one takes five cordic runs, ten bit-serial multiplies, its slot
// step and four emit steps.
// each survivor gives four vertex words; the last word of a tick carries last,
// and a tick without survivors returns one empty word.
// req.ready is high only between items; the result register lets the next item
// be taken while a word still waits. while a word waits with rsp.ready low the
// sequencer holds at a reply, the final word or an emit with the hold word full.
// reset frees all slots, clears radius and life, and sets radius_step to 16.
module rotated_sprite_particle_pool_top
    import rspp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    rspp_req_if.sink   req,
    rspp_rsp_if.source rsp,
    input  logic       cfg_wr_en,
    input  logic [9:0] cfg_wr_data
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_SPAWN = 4'd1;
    localparam logic [3:0] ST_REPLY = 4'd2;
    localparam logic [3:0] ST_SLOT  = 4'd3;
    localparam logic [3:0] ST_CORD  = 4'd4;
    localparam logic [3:0] ST_MULX  = 4'd5;
    localparam logic [3:0] ST_MULY  = 4'd6;
    localparam logic [3:0] ST_EMIT  = 4'd7;
    localparam logic [3:0] ST_FIN   = 4'd8;

    localparam logic [2:0] CORNER_LU = 3'd0;
    localparam logic [2:0] CORNER_RU = 3'd1;
    localparam logic [2:0] CORNER_LD = 3'd2;
    localparam logic [2:0] CORNER_RD = 3'd3;
    localparam logic [2:0] K_BASE    = 3'd4;

    localparam logic [1:0] OSEL_REPLY = 2'd0;
    localparam logic [1:0] OSEL_HOLD  = 2'd1;
    localparam logic [1:0] OSEL_EMPTY = 2'd2;

    logic [9:0]               radius_step_reg;
    logic [SLOTS-1:0]         live_reg;
    logic [15:0]              radius_reg [SLOTS];
    logic [15:0]              life_reg [SLOTS];
    logic signed [15:0]       axis_x_reg [SLOTS];
    logic signed [15:0]       axis_y_reg [SLOTS];
    logic [15:0]              travel_reg [SLOTS];
    logic [15:0]              cangle_reg [SLOTS];
    logic [LEN_W-1:0]         hdiag_reg [SLOTS];
    color_t                   color_reg [SLOTS];
    logic [31:0]              delta_reg [SLOTS];

    logic [3:0]               state_reg, state_next;
    logic [SLOT_W-1:0]        sl_reg, sl_next;
    logic [2:0]               k_reg, k_next;

    logic signed [15:0]       lat_cx_reg, lat_cy_reg;
    logic [15:0]              lat_ang_reg, lat_life_reg;
    logic [31:0]              lat_color_reg, lat_step_reg;

    logic signed [PX_W-1:0]   px_reg, py_reg;
    logic signed [15:0]       vx_reg, vy_reg;

    logic                     out_valid_reg;
    logic                     out_is_vertex_reg, out_spawn_ok_reg, out_last_reg;
    logic [SLOT_W-1:0]        out_slot_reg;
    logic [1:0]               out_corner_reg;
    logic signed [15:0]       out_x_reg, out_y_reg;
    logic [31:0]              out_color_reg;

    logic                     hold_valid_reg;
    logic [SLOT_W-1:0]        hold_slot_reg;
    logic [1:0]               hold_corner_reg;
    logic signed [15:0]       hold_x_reg, hold_y_reg;
    logic [31:0]              hold_color_reg;

    cord_cmd_t                cord_cmd;
    logic                     cord_busy;
    logic signed [TRIG_W-1:0] cord_cos, cord_sin;
    logic [15:0]              cord_atan;
    logic                     mul_start, mul_busy;
    logic [LEN_W-1:0]         mul_len;
    logic signed [TRIG_W-1:0] mul_fac;
    logic signed [PQ_W-1:0]   mul_prod;
    logic                     sqrt_start, sqrt_busy;
    logic [LEN_W-1:0]         sqrt_root;

    logic                     out_free, out_load, hold_load, hold_clear;
    logic [1:0]               out_sel;
    logic                     accept, adv, spawn_wr, slot_upd, slot_kill, x_load, y_load;
    logic [SLOT_W-1:0]        free_idx;
    logic                     free_found;
    logic [16:0]              radius_sum;
    logic [15:0]              radius_new;

    function automatic logic [15:0] corner_ang(input logic [2:0] k, input logic [15:0] rot,
                                               input logic [15:0] a);
        logic [15:0] v;
        case (k)
            CORNER_LU: v = rot + 16'h8000 + a;
            CORNER_RU: v = rot - a;
            CORNER_LD: v = rot + 16'h8000 - a;
            default:   v = rot + a;
        endcase
        return v;
    endfunction

    function automatic color_t color_add(input color_t cur, input logic [31:0] dlt);
        logic signed [10:0] s;
        color_t             res;
        for (int ch = 0; ch < 4; ch++)
        begin
            s = 11'($signed(cur[ch])) + 11'($signed(dlt[8*ch +: 8]));
            if (s < -11'sd512)
            begin
                res[ch] = 10'h200;
            end
            else if (s > 11'sd511)
            begin
                res[ch] = 10'h1FF;
            end
            else
            begin
                res[ch] = s[9:0];
            end
        end
        return res;
    endfunction

    function automatic logic [31:0] color_pack(input color_t c);
        logic [31:0] w;
        for (int ch = 0; ch < 4; ch++)
        begin
            if ($signed(c[ch]) < 0)
            begin
                w[8*ch +: 8] = 8'd0;
            end
            else if ($signed(c[ch]) > 10'sd255)
            begin
                w[8*ch +: 8] = 8'hFF;
            end
            else
            begin
                w[8*ch +: 8] = c[ch][7:0];
            end
        end
        return w;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [VS_W-1:0] v);
        logic signed [15:0] r;
        if (v < -22'sd32768)
        begin
            r = -16'sd32768;
        end
        else if (v > 22'sd32767)
        begin
            r = 16'sd32767;
        end
        else
        begin
            r = v[15:0];
        end
        return r;
    endfunction

    rspp_cordic u_cordic (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cord_cmd),
        .busy     (cord_busy),
        .cos_val  (cord_cos),
        .sin_val  (cord_sin),
        .atan_val (cord_atan)
    );

    rspp_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .len   (mul_len),
        .fac   (mul_fac),
        .busy  (mul_busy),
        .prod  (mul_prod)
    );

    rspp_sqrt u_sqrt (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (sqrt_start),
        .size_x (req.size_x),
        .size_y (req.size_y),
        .busy   (sqrt_busy),
        .root   (sqrt_root)
    );

    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;
    assign out_free  = !out_valid_reg || rsp.ready;

    always_comb
    begin
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!live_reg[i])
            begin
                free_idx = SLOT_W'(i);
            end
        end
    end
    assign free_found = !(&live_reg);

    assign radius_sum = {1'b0, radius_reg[sl_reg]} + {7'd0, radius_step_reg};
    assign radius_new = radius_sum[16] ? 16'hFFFF : radius_sum[15:0];

    always_comb
    begin
        state_next      = state_reg;
        sl_next         = sl_reg;
        k_next          = k_reg;
        cord_cmd        = '0;
        cord_cmd.size_x = req.size_x;
        cord_cmd.size_y = req.size_y;
        sqrt_start      = 1'b0;
        mul_start       = 1'b0;
        mul_len         = hdiag_reg[sl_reg];
        mul_fac         = cord_cos;
        out_load        = 1'b0;
        out_sel         = OSEL_REPLY;
        hold_load       = 1'b0;
        hold_clear      = 1'b0;
        adv             = 1'b0;
        spawn_wr        = 1'b0;
        slot_upd        = 1'b0;
        slot_kill       = 1'b0;
        x_load          = 1'b0;
        y_load          = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req.kind == KIND_SPAWN)
                    begin
                        cord_cmd.start = 1'b1;
                        cord_cmd.vec   = 1'b1;
                        sqrt_start     = 1'b1;
                        state_next     = ST_SPAWN;
                    end
                    else
                    begin
                        sl_next    = '0;
                        state_next = ST_SLOT;
                    end
                end
            end
            ST_SPAWN:
            begin
                if (!cord_busy && !sqrt_busy)
                begin
                    state_next = ST_REPLY;
                end
            end
            ST_REPLY:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    out_sel    = OSEL_REPLY;
                    spawn_wr   = free_found;
                    state_next = ST_IDLE;
                end
            end
            ST_SLOT:
            begin
                if (!live_reg[sl_reg])
                begin
                    adv = 1'b1;
                end
                else
                begin
                    slot_upd = 1'b1;
                    if (life_reg[sl_reg] <= 16'd1)
                    begin
                        slot_kill = 1'b1;
                        adv       = 1'b1;
                    end
                    else
                    begin
                        cord_cmd.start = 1'b1;
                        cord_cmd.angle = travel_reg[sl_reg];
                        k_next         = K_BASE;
                        state_next     = ST_CORD;
                    end
                end
            end
            ST_CORD:
            begin
                if (!cord_busy)
                begin
                    mul_start  = 1'b1;
                    mul_len    = (k_reg == K_BASE) ? LEN_W'(radius_reg[sl_reg])
                                                   : hdiag_reg[sl_reg];
                    state_next = ST_MULX;
                end
            end
            ST_MULX:
            begin
                if (!mul_busy)
                begin
                    x_load     = 1'b1;
                    mul_start  = 1'b1;
                    mul_len    = (k_reg == K_BASE) ? LEN_W'(radius_reg[sl_reg])
                                                   : hdiag_reg[sl_reg];
                    mul_fac    = cord_sin;
                    state_next = ST_MULY;
                end
            end
            ST_MULY:
            begin
                if (!mul_busy)
                begin
                    y_load = 1'b1;
                    if (k_reg == K_BASE)
                    begin
                        k_next         = CORNER_LU;
                        cord_cmd.start = 1'b1;
                        cord_cmd.angle = corner_ang(CORNER_LU, travel_reg[sl_reg],
                                                    cangle_reg[sl_reg]);
                        state_next     = ST_CORD;
                    end
                    else
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                if (!hold_valid_reg || out_free)
                begin
                    hold_load = 1'b1;
                    out_load  = hold_valid_reg;
                    out_sel   = OSEL_HOLD;
                    if (k_reg == CORNER_RD)
                    begin
                        adv = 1'b1;
                    end
                    else
                    begin
                        k_next         = k_reg + 3'd1;
                        cord_cmd.start = 1'b1;
                        cord_cmd.angle = corner_ang(k_reg + 3'd1, travel_reg[sl_reg],
                                                    cangle_reg[sl_reg]);
                        state_next     = ST_CORD;
                    end
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    out_sel    = hold_valid_reg ? OSEL_HOLD : OSEL_EMPTY;
                    hold_clear = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (adv)
        begin
            if (sl_reg == SLOT_W'(SLOTS - 1))
            begin
                state_next = ST_FIN;
            end
            else
            begin
                sl_next    = sl_reg + 1'b1;
                state_next = ST_SLOT;
            end
        end
    end

    // control state, radius_step, word valid flags, slot liveness, life and radius
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            sl_reg          <= '0;
            k_reg           <= '0;
            radius_step_reg <= RADIUS_STEP_RESET;
            live_reg        <= '0;
            out_valid_reg   <= 1'b0;
            hold_valid_reg  <= 1'b0;
            for (int i = 0; i < SLOTS; i++)
            begin
                radius_reg[i] <= '0;
                life_reg[i]   <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            sl_reg    <= sl_next;
            k_reg     <= k_next;
            if (cfg_wr_en)
            begin
                radius_step_reg <= cfg_wr_data;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (hold_clear)
            begin
                hold_valid_reg <= 1'b0;
            end
            else if (hold_load)
            begin
                hold_valid_reg <= 1'b1;
            end
            if (spawn_wr)
            begin
                live_reg[free_idx] <= 1'b1;
                life_reg[free_idx] <= lat_life_reg;
            end
            if (slot_kill)
            begin
                live_reg[sl_reg]   <= 1'b0;
                life_reg[sl_reg]   <= '0;
                radius_reg[sl_reg] <= '0;
            end
            else if (slot_upd)
            begin
                life_reg[sl_reg]   <= life_reg[sl_reg] - 16'd1;
                radius_reg[sl_reg] <= radius_new;
            end
        end
    end

    // slot payload store and datapath words
    always_ff @(posedge clk)
    begin
        if (accept && req.kind == KIND_SPAWN)
        begin
            lat_cx_reg    <= req.center_x;
            lat_cy_reg    <= req.center_y;
            lat_ang_reg   <= req.fire_angle;
            lat_color_reg <= req.start_color;
            lat_step_reg  <= req.color_step;
            lat_life_reg  <= req.lifetime;
        end
        if (spawn_wr)
        begin
            axis_x_reg[free_idx] <= lat_cx_reg;
            axis_y_reg[free_idx] <= lat_cy_reg;
            travel_reg[free_idx] <= lat_ang_reg;
            cangle_reg[free_idx] <= cord_atan;
            hdiag_reg[free_idx]  <= sqrt_root;
            delta_reg[free_idx]  <= lat_step_reg;
            for (int ch = 0; ch < 4; ch++)
            begin
                color_reg[free_idx][ch] <= {2'b00, lat_color_reg[8*ch +: 8]};
            end
        end
        if (slot_upd)
        begin
            color_reg[sl_reg] <= color_add(color_reg[sl_reg], delta_reg[sl_reg]);
        end
        if (x_load)
        begin
            if (k_reg == K_BASE)
            begin
                px_reg <= PX_W'(axis_x_reg[sl_reg]) + PX_W'(mul_prod);
            end
            else
            begin
                vx_reg <= sat16(VS_W'(px_reg) + VS_W'(mul_prod));
            end
        end
        if (y_load)
        begin
            if (k_reg == K_BASE)
            begin
                py_reg <= PX_W'(axis_y_reg[sl_reg]) + PX_W'(mul_prod);
            end
            else
            begin
                vy_reg <= sat16(VS_W'(py_reg) + VS_W'(mul_prod));
            end
        end
        if (hold_load)
        begin
            hold_slot_reg   <= sl_reg;
            hold_corner_reg <= k_reg[1:0];
            hold_x_reg      <= vx_reg;
            hold_y_reg      <= vy_reg;
            hold_color_reg  <= color_pack(color_reg[sl_reg]);
        end
        if (out_load)
        begin
            unique case (out_sel)
                OSEL_REPLY:
                begin
                    out_is_vertex_reg <= 1'b0;
                    out_spawn_ok_reg  <= free_found;
                    out_slot_reg      <= free_found ? free_idx : '0;
                    out_corner_reg    <= '0;
                    out_x_reg         <= '0;
                    out_y_reg         <= '0;
                    out_color_reg     <= '0;
                    out_last_reg      <= 1'b1;
                end
                OSEL_HOLD:
                begin
                    out_is_vertex_reg <= 1'b1;
                    out_spawn_ok_reg  <= 1'b0;
                    out_slot_reg      <= hold_slot_reg;
                    out_corner_reg    <= hold_corner_reg;
                    out_x_reg         <= hold_x_reg;
                    out_y_reg         <= hold_y_reg;
                    out_color_reg     <= hold_color_reg;
                    out_last_reg      <= (state_reg == ST_FIN);
                end
                default:
                begin
                    out_is_vertex_reg <= 1'b0;
                    out_spawn_ok_reg  <= 1'b0;
                    out_slot_reg      <= '0;
                    out_corner_reg    <= '0;
                    out_x_reg         <= '0;
                    out_y_reg         <= '0;
                    out_color_reg     <= '0;
                    out_last_reg      <= 1'b1;
                end
            endcase
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.is_vertex    = out_is_vertex_reg;
    assign rsp.spawn_ok     = out_spawn_ok_reg;
    assign rsp.slot_index   = out_slot_reg;
    assign rsp.corner       = out_corner_reg;
    assign rsp.vertex_x     = out_x_reg;
    assign rsp.vertex_y     = out_y_reg;
    assign rsp.vertex_color = out_color_reg;
    assign rsp.last         = out_last_reg;

endmodule

// ===== rtl/rspp_checker.sv =====
// port-level checks of the particle pool and their binding to the top level
module rspp_checker
    import rspp_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               rsp_valid,
    input logic               rsp_ready,
    input logic               rsp_is_vertex,
    input logic               rsp_spawn_ok,
    input logic [1:0]         rsp_corner,
    input logic signed [15:0] rsp_vertex_x,
    input logic [31:0]        rsp_vertex_color,
    input logic               rsp_last
);

    // a stalled word stays offered
    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result word dropped while stalled");

    // a vertex word never reports a spawn
    a_vertex_no_spawn: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_is_vertex |-> !rsp_spawn_ok)
        else $error("vertex word carries spawn_ok");

    // replies and empty ticks are single words with cleared geometry
    a_reply_shape: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_is_vertex |-> rsp_last && rsp_corner == 2'd0
            && rsp_vertex_x == 16'sd0 && rsp_vertex_color == 32'd0)
        else $error("malformed reply word");

    // a tick's word stream never ends on a corner other than right down
    a_last_corner: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_is_vertex && rsp_last |-> rsp_corner == 2'd3)
        else $error("tick ended mid-quad");

endmodule

bind rotated_sprite_particle_pool_top rspp_checker u_rspp_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_is_vertex    (rsp.is_vertex),
    .rsp_spawn_ok     (rsp.spawn_ok),
    .rsp_corner       (rsp.corner),
    .rsp_vertex_x     (rsp.vertex_x),
    .rsp_vertex_color (rsp.vertex_color),
    .rsp_last         (rsp.last)
);

// ===== dv/tb_rotated_sprite_particle_pool_top.sv =====
// self-checking testbench of the rotated sprite particle pool with its own slot predictor
module tb_rotated_sprite_particle_pool_top;
    import rspp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DRAIN_CYCLES = 400;
    localparam int STALL_LIMIT  = 20000;
    localparam int LONG_HOLD    = 500;
    localparam int RAND_PER_SET = 120;

    typedef struct packed {
        logic               is_vertex;
        logic               spawn_ok;
        logic [3:0]         slot_index;
        logic [1:0]         corner;
        logic signed [15:0] vertex_x;
        logic signed [15:0] vertex_y;
        logic [31:0]        vertex_color;
        logic               last;
    } word_t;

    typedef struct {
        logic               kind;
        logic signed [15:0] center_x;
        logic signed [15:0] center_y;
        logic [14:0]        size_x;
        logic [14:0]        size_y;
        logic [15:0]        fire_angle;
        logic [31:0]        start_color;
        logic [31:0]        color_step;
        logic [15:0]        lifetime;
        bit                 typed;
        word_t              want;
    } particle_cmd_t;

    localparam longint ARCTAN [16] = '{
        2097152, 1238021, 654136, 332050, 166669, 83416, 41718, 20860,
        10430, 5215, 2608, 1304, 652, 326, 163, 81
    };

    logic       clk;
    logic       rst_n;
    logic       cfg_wr_en;
    logic [9:0] cfg_wr_data;

    rspp_req_if req();
    rspp_rsp_if rsp();

    rotated_sprite_particle_pool_top uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .rsp         (rsp),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // predictor state
    logic [9:0]         growth;
    bit                 live      [SLOTS];
    logic signed [15:0] pos_x     [SLOTS];
    logic signed [15:0] pos_y     [SLOTS];
    logic [15:0]        heading   [SLOTS];
    logic [15:0]        spread    [SLOTS];
    longint             diag      [SLOTS];
    longint             rad       [SLOTS];
    int                 shade     [SLOTS][4];
    logic [31:0]        shade_inc [SLOTS];
    longint             life      [SLOTS];

    word_t         pending_words[$];
    particle_cmd_t stim_table[$];
    int            mismatches;
    int            idle_cycles;
    bit            sending_done;
    bit            hold_request;
    bit            burst;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic void cordic_trig(input logic [15:0] a, output longint c,
                                        output longint s);
        int unsigned q;
        logic [15:0] r;
        longint x, y, z, nx, ny;
        q = ((int'(a) + 8192) >> 14) & 3;
        r = a - 16'(q * 16384);
        z = longint'($signed(r)) * 256;
        x = 652032874;
        y = 0;
        for (int i = 0; i < 16; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i); ny = y + (x >>> i); z -= ARCTAN[i];
            end
            else
            begin
                nx = x + (y >>> i); ny = y - (x >>> i); z += ARCTAN[i];
            end
            x = nx; y = ny;
        end
        case (q)
            0: begin c = x;  s = y;  end
            1: begin c = -y; s = x;  end
            2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endfunction

    function automatic logic [15:0] cordic_atan(input logic [14:0] sx, input logic [14:0] sy);
        longint x, y, z, nx, ny, a;
        if (sx == 0 && sy == 0)
            return 16'd0;
        x = longint'(sx) * 32768;
        y = longint'(sy) * 32768;
        z = 0;
        for (int i = 0; i < 16; i++)
        begin
            if (y < 0)
            begin
                nx = x - (y >>> i); ny = y + (x >>> i); z -= ARCTAN[i];
            end
            else
            begin
                nx = x + (y >>> i); ny = y - (x >>> i); z += ARCTAN[i];
            end
            x = nx; y = ny;
        end
        a = (z + 128) >>> 8;
        if (a < 0) a = 0;
        if (a > 16384) a = 16384;
        return 16'(a);
    endfunction

    function automatic longint diag_len(input logic [14:0] sx, input logic [14:0] sy);
        longint unsigned n, m, r, b;
        n = longint'(sx) * sx + longint'(sy) * sy;
        m = n;
        r = 0;
        b = 64'd1 << 32;
        while (b > m) b >>= 2;
        while (b != 0)
        begin
            if (m >= r + b)
            begin
                m -= r + b; r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        if (n - r * r > r) r++;
        return longint'(r);
    endfunction

    function automatic longint scale(input longint len, input longint t);
        return (len * t + (64'sd1 <<< 29)) >>> 30;
    endfunction

    function automatic logic signed [15:0] clip16(input longint v);
        if (v < -32768) v = -32768;
        if (v > 32767) v = 32767;
        return 16'(v);
    endfunction

    function automatic logic [31:0] shade_word(input int k);
        logic [31:0] w;
        int v;
        w = '0;
        for (int ch = 0; ch < 4; ch++)
        begin
            v = shade[k][ch];
            if (v < 0) v = 0;
            if (v > 255) v = 255;
            w[24 - 8 * ch +: 8] = 8'(v);
        end
        return w;
    endfunction

    function automatic void pool_advance(input particle_cmd_t c);
        word_t w;
        longint cr, sr, cc, sc, px, py;
        logic [15:0] ang;
        int v, n;
        w = '0;
        if (c.kind == KIND_SPAWN)
        begin
            w.last = 1'b1;
            for (int k = 0; k < SLOTS; k++)
            begin
                if (live[k]) continue;
                live[k] = 1;
                pos_x[k] = c.center_x;
                pos_y[k] = c.center_y;
                diag[k] = diag_len(c.size_x, c.size_y);
                spread[k] = cordic_atan(c.size_x, c.size_y);
                heading[k] = c.fire_angle;
                for (int ch = 0; ch < 4; ch++)
                    shade[k][ch] = int'(c.start_color[24 - 8 * ch +: 8]);
                shade_inc[k] = c.color_step;
                life[k] = c.lifetime;
                w.spawn_ok = 1'b1;
                w.slot_index = 4'(k);
                break;
            end
            pending_words.push_back(w);
            return;
        end
        n = 0;
        for (int k = 0; k < SLOTS; k++)
        begin
            if (!live[k]) continue;
            for (int ch = 0; ch < 4; ch++)
            begin
                v = shade[k][ch] + int'($signed(shade_inc[k][24 - 8 * ch +: 8]));
                if (v < -512) v = -512;
                if (v > 511) v = 511;
                shade[k][ch] = v;
            end
            if (life[k] <= 1)
            begin
                live[k] = 0;
                life[k] = 0;
                rad[k] = 0;
                continue;
            end
            life[k]--;
            rad[k] += growth;
            if (rad[k] > 65535) rad[k] = 65535;
            cordic_trig(heading[k], cr, sr);
            px = longint'(pos_x[k]) + scale(rad[k], cr);
            py = longint'(pos_y[k]) + scale(rad[k], sr);
            for (int q = 0; q < 4; q++)
            begin
                case (q)
                    0: ang = heading[k] + 16'd32768 + spread[k];
                    1: ang = heading[k] - spread[k];
                    2: ang = heading[k] + 16'd32768 - spread[k];
                    default: ang = heading[k] + spread[k];
                endcase
                cordic_trig(ang, cc, sc);
                w = '0;
                w.is_vertex = 1'b1;
                w.slot_index = 4'(k);
                w.corner = 2'(q);
                w.vertex_x = clip16(px + scale(diag[k], cc));
                w.vertex_y = clip16(py + scale(diag[k], sc));
                w.vertex_color = shade_word(k);
                pending_words.push_back(w);
                n++;
            end
        end
        if (n == 0)
        begin
            w = '0;
            w.last = 1'b1;
            pending_words.push_back(w);
        end
        else
            pending_words[$].last = 1'b1;
    endfunction

    function automatic particle_cmd_t make_cmd(input logic kind, input logic [15:0] cx,
                                               input logic [15:0] cy, input logic [14:0] sx,
                                               input logic [14:0] sy, input logic [15:0] ang,
                                               input logic [31:0] col, input logic [31:0] stp,
                                               input logic [15:0] lf);
        particle_cmd_t c;
        c.kind = kind;
        c.center_x = cx;
        c.center_y = cy;
        c.size_x = sx;
        c.size_y = sy;
        c.fire_angle = ang;
        c.start_color = col;
        c.color_step = stp;
        c.lifetime = lf;
        c.typed = 0;
        c.want = '0;
        return c;
    endfunction

    function automatic particle_cmd_t random_cmd();
        logic [15:0] lf;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 2)
            lf = 16'($urandom_range(100, 65535));
        else if (pick < 30)
            lf = 16'($urandom_range(7, 40));
        else
            lf = 16'($urandom_range(0, 6));
        return make_cmd($urandom_range(0, 99) < 45 ? KIND_TICK : KIND_SPAWN,
                        16'($urandom), 16'($urandom), 15'($urandom), 15'($urandom),
                        16'($urandom), $urandom, $urandom, lf);
    endfunction

    task automatic send_cmd(input particle_cmd_t c);
        int gap;
        if (burst)
            gap = 0;
        else if ($urandom_range(0, 9) < 6)
            gap = 0;
        else if ($urandom_range(0, 9) < 8)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(10, 60);
        if (gap > 0)
        begin
            req.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req.valid = 1'b1;
        req.kind = c.kind;
        req.center_x = c.center_x;
        req.center_y = c.center_y;
        req.size_x = c.size_x;
        req.size_y = c.size_y;
        req.fire_angle = c.fire_angle;
        req.start_color = c.start_color;
        req.color_step = c.color_step;
        req.lifetime = c.lifetime;
        forever
        begin
            @(posedge clk);
            if (req.ready) break;
        end
        pool_advance(c);
        if (c.typed)
        begin
            void'(pending_words.pop_back());
            pending_words.push_back(c.want);
        end
        @(negedge clk);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        req.valid = 1'b0;
        while (pending_words.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic set_growth(input logic [9:0] value);
        cfg_wr_en = 1'b1;
        cfg_wr_data = value;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        growth = value;
    endtask

    task automatic random_run(input int count);
        for (int i = 0; i < count; i++)
        begin
            if (i % 30 == 0)
                burst = ($urandom_range(0, 3) == 0);
            send_cmd(random_cmd());
        end
        burst = 0;
    endtask

    // receiver with random back pressure and one long hold
    initial
    begin
        rsp.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                rsp.ready = 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                hold_request = 0;
            end
            else if (burst || $urandom_range(0, 9) < 7)
                rsp.ready = 1'b1;
            else if ($urandom_range(0, 9) < 8)
                rsp.ready = 1'b0;
            else
            begin
                rsp.ready = 1'b0;
                repeat ($urandom_range(10, 80)) @(negedge clk);
            end
        end
    end

    // result checker
    initial
    begin
        word_t got, exp;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp.valid && rsp.ready)
            begin
                got = '{rsp.is_vertex, rsp.spawn_ok, rsp.slot_index, rsp.corner,
                        rsp.vertex_x, rsp.vertex_y, rsp.vertex_color, rsp.last};
                if (pending_words.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected word %h", got);
                end
                else
                begin
                    exp = pending_words.pop_front();
                    if (got !== exp)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch exp v%0d ok%0d s%0d c%0d x%0d y%0d col%h l%0d"
                                     , exp.is_vertex, exp.spawn_ok, exp.slot_index, exp.corner
                                     , exp.vertex_x, exp.vertex_y, exp.vertex_color, exp.last);
                        if (mismatches <= 10)
                            $display("         got v%0d ok%0d s%0d c%0d x%0d y%0d col%h l%0d"
                                     , got.is_vertex, got.spawn_ok, got.slot_index, got.corner
                                     , got.vertex_x, got.vertex_y, got.vertex_color, got.last);
                    end
                end
            end
        end
    end

    // watchdog on cycles without any accepted word
    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
                idle_cycles = 0;
            else if (!sending_done || pending_words.size() != 0)
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("rotated_sprite_particle_pool_top regression: fail");
                $finish;
            end
        end
    end

    initial
    begin
        particle_cmd_t c;
        word_t w;
        mismatches = 0;
        sending_done = 0;
        hold_request = 0;
        burst = 0;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        req.valid = 1'b0;
        req.kind = KIND_SPAWN;
        req.center_x = '0;
        req.center_y = '0;
        req.size_x = '0;
        req.size_y = '0;
        req.fire_angle = '0;
        req.start_color = '0;
        req.color_step = '0;
        req.lifetime = '0;
        growth = RADIUS_STEP_RESET;
        for (int k = 0; k < SLOTS; k++)
        begin
            live[k] = 0; rad[k] = 0; life[k] = 0;
        end

        // empty tick after reset
        c = make_cmd(KIND_TICK, 0, 0, 0, 0, 0, 0, 0, 0);
        c.typed = 1; c.want = '0; c.want.last = 1'b1;
        stim_table.push_back(c);
        // zero size, zero life, into slot 0
        c = make_cmd(KIND_SPAWN, 16'h7FFF, 16'h7FFF, 0, 0, 0, 32'h00000000, 32'h7F7F7F7F, 0);
        c.typed = 1; c.want = '0; c.want.spawn_ok = 1'b1; c.want.last = 1'b1;
        stim_table.push_back(c);
        stim_table.push_back(make_cmd(KIND_SPAWN, 16'h8000, 16'h8000, 15'h7FFF, 15'h7FFF,
                                      16'hFFFF, 32'hFFFFFFFF, 32'h7F7F7F7F, 16'hFFFF));
        stim_table.push_back(make_cmd(KIND_SPAWN, 16'h8000, 16'h7FFF, 15'h7FFF, 0, 16'h4000,
                                      32'h00FF00FF, 32'h80808080, 1));
        stim_table.push_back(make_cmd(KIND_SPAWN, 16'h0100, 16'hFF00, 15'h7FFF, 0, 16'h8000,
                                      32'h80808080, 32'h80018001, 3));
        stim_table.push_back(make_cmd(KIND_SPAWN, 16'hFF00, 16'h0100, 0, 15'h7FFF, 16'hC000,
                                      32'h12345678, 32'h01FF7F80, 3));
        for (int i = 0; i < 3; i++)
            stim_table.push_back(make_cmd(KIND_TICK, 16'hFFFF, 16'hFFFF, 15'h7FFF, 15'h7FFF,
                                          16'hFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF));
        for (int i = 0; i < 15; i++)
            stim_table.push_back(make_cmd(KIND_SPAWN, 16'(i * 977), 16'(i * 1301),
                                          15'(i * 2000), 15'(30000 - i * 1900),
                                          16'(i * 4369), 32'(i * 32'h11111111),
                                          32'hF0F0F0F0, 2));
        // pool full
        c = make_cmd(KIND_SPAWN, 16'h1234, 16'h4321, 15'h0100, 15'h0100, 16'h1000,
                     32'hFFFFFFFF, 32'h01010101, 16'h0005);
        c.typed = 1; c.want = '0; c.want.last = 1'b1;
        stim_table.push_back(c);
        stim_table.push_back(make_cmd(KIND_TICK, 0, 0, 0, 0, 0, 0, 0, 0));
        stim_table.push_back(make_cmd(KIND_TICK, 0, 0, 0, 0, 0, 0, 0, 0));

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        set_growth(RADIUS_STEP_RESET);
        foreach (stim_table[i])
            send_cmd(stim_table[i]);
        wait_idle();

        set_growth(10'd1023);
        hold_request = 1;
        random_run(RAND_PER_SET);
        wait_idle();

        set_growth(10'd0);
        random_run(RAND_PER_SET);
        wait_idle();

        set_growth(10'($urandom_range(1, 1022)));
        random_run(RAND_PER_SET);
        wait_idle();
        sending_done = 1;

        if (mismatches == 0 && pending_words.size() == 0)
            $display("rotated_sprite_particle_pool_top regression: pass");
        else
            $display("rotated_sprite_particle_pool_top regression: fail");
        $finish;
    end

endmodule
